@@ hw/rtl/fpec_pkg.sv @@
package fpec_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam logic [31:0] RADIUS_SCALE_RST = 32'd3 << (FRAC_BITS_DEF - 1);

    localparam logic [2:0] FUNC_LOAD_PROJ = 3'd0;
    localparam logic [2:0] FUNC_LOAD_VIEW = 3'd1;
    localparam logic [2:0] FUNC_BUILD     = 3'd2;
    localparam logic [2:0] FUNC_SPHERE    = 3'd3;
    localparam logic [2:0] FUNC_POINT     = 3'd4;

    typedef struct packed {
        logic [2:0]         func;
        logic [3:0]         elem_index;
        logic signed [31:0] elem_value;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [30:0]        sphere_radius;
    } in_item_t;

    typedef struct packed {
        logic inside_res;
        logic degenerate;
    } out_item_t;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_NONE     = 4'd0,
        OP_LOAD     = 4'd1,
        OP_CLIP_MAC = 4'd2,
        OP_CLIP_WR  = 4'd3,
        OP_RAW      = 4'd4,
        OP_SQ_MAC   = 4'd5,
        OP_SQRT     = 4'd6,
        OP_DIV      = 4'd7,
        OP_DIST_MAC = 4'd8,
        OP_DIST_CMP = 4'd9,
        OP_SR       = 4'd10
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [4:0] idx_a;   // clip element / plane
        logic [1:0] idx_k;   // inner index
        logic       first;   // clear accumulator / start unit
    } dp_cmd_t;

    typedef struct packed {
        logic unit_done;
    } dp_stat_t;

endpackage

@@ hw/rtl/fpec_datapath.sv @@
module fpec_datapath #(
    parameter int FRAC_BITS = fpec_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  fpec_pkg::in_item_t item,
    input  logic [31:0]        radius_scale,
    input  fpec_pkg::dp_cmd_t  cmd,
    output fpec_pkg::dp_stat_t stat,
    output logic               in_frustum,
    output logic               degen
);
    import fpec_pkg::*;

    logic signed [31:0] proj_reg [16];
    logic signed [31:0] view_reg [16];
    logic signed [31:0] clip_reg [16];
    logic signed [31:0] plane_reg [24];
    logic signed [31:0] raw_reg [4];

    logic signed [65:0] acc_reg;
    logic [63:0]        sumsq_reg;
    logic signed [63:0] sr_reg;
    logic               inside_reg;
    logic               degen_reg;

    // sqrt / divide shared iterative unit state
    logic [63:0] rem_reg;
    logic [63:0] root_reg;
    logic [5:0]  cnt_reg;
    logic [32:0] len_reg;
    logic        len_zero_reg;
    logic [63:0] num_reg;
    logic [63:0] quo_reg;
    logic [64:0] drem_reg;
    logic        neg_reg;
    logic        done_reg;

    logic signed [31:0] ma;
    logic signed [31:0] mb;
    logic signed [63:0] prod;
    logic signed [63:0] prod_fl;
    logic [63:0]        sq_prod;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -66'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    logic [1:0] col;
    logic       add_sel;
    logic [2:0] pidx;

    always_comb
    begin
        pidx    = cmd.idx_a[2:0];
        col     = pidx[2:1];
        add_sel = (pidx == 3'd1) || (pidx == 3'd2) || (pidx == 3'd5);
        ma = '0;
        mb = '0;
        case (cmd.op)
            OP_CLIP_MAC:
            begin
                ma = view_reg[{cmd.idx_a[3:2], cmd.idx_k}];
                mb = proj_reg[{cmd.idx_k, cmd.idx_a[1:0]}];
            end
            OP_SQ_MAC:
            begin
                ma = raw_reg[cmd.idx_k];
                mb = raw_reg[cmd.idx_k];
            end
            OP_DIST_MAC:
            begin
                ma = plane_reg[{pidx, cmd.idx_k}];
                case (cmd.idx_k)
                    2'd0: mb = item.pos_x;
                    2'd1: mb = item.pos_y;
                    default: mb = item.pos_z;
                endcase
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
        prod    = ma * mb;
        prod_fl = prod >>> FRAC_BITS;
        sq_prod = prod;
    end

    logic [63:0] sr_prod;
    assign sr_prod = {33'd0, item.sphere_radius} * {32'd0, radius_scale};

    logic [63:0] trial;
    logic [63:0] bitv;
    logic [63:0] root_step;
    assign bitv      = 64'd1 << (7'd62 - {cnt_reg, 1'b0});
    assign trial     = root_reg + bitv;
    assign root_step = (rem_reg >= trial) ? ((root_reg >> 1) + bitv) : (root_reg >> 1);

    logic [64:0] dtrial;
    assign dtrial = {drem_reg[63:0], num_reg[63]} - {32'd0, len_reg};

    // last iteration of the sqrt or of one divide
    logic unit_fin;
    assign unit_fin = !cmd.first &&
                      (((cmd.op == OP_SQRT) && (cnt_reg == 6'd31)) ||
                       ((cmd.op == OP_DIV) && ((cnt_reg == 6'd63) || len_zero_reg)));

    logic signed [65:0] dist_full;
    assign dist_full = acc_reg + 66'(plane_reg[{pidx, 2'd3}]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
            begin
                proj_reg[i] <= '0;
                view_reg[i] <= '0;
            end
            for (int i = 0; i < 24; i++)
                plane_reg[i] <= '0;
            inside_reg <= 1'b0;
            degen_reg  <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= unit_fin;
            case (cmd.op)
                OP_LOAD:
                begin
                    inside_reg <= (item.func == FUNC_SPHERE) || (item.func == FUNC_POINT);
                    degen_reg  <= 1'b0;
                    if (item.func == FUNC_LOAD_PROJ)
                        proj_reg[item.elem_index] <= item.elem_value;
                    else if (item.func == FUNC_LOAD_VIEW)
                        view_reg[item.elem_index] <= item.elem_value;
                end
                OP_CLIP_MAC:
                    acc_reg <= (cmd.first ? 66'sd0 : acc_reg) + 66'(prod_fl);
                OP_CLIP_WR:
                    clip_reg[cmd.idx_a[3:0]] <= sat32(acc_reg);
                OP_RAW:
                    for (int k = 0; k < 4; k++)
                        raw_reg[k] <= add_sel
                            ? sat32(66'(clip_reg[{2'(k), 2'd3}]) + 66'(clip_reg[{2'(k), col}]))
                            : sat32(66'(clip_reg[{2'(k), 2'd3}]) - 66'(clip_reg[{2'(k), col}]));
                OP_SQ_MAC:
                    sumsq_reg <= (cmd.first ? 64'd0 : sumsq_reg) + sq_prod;
                OP_SQRT:
                begin
                    if (cmd.first)
                    begin
                        rem_reg  <= sumsq_reg;
                        root_reg <= '0;
                        cnt_reg  <= '0;
                    end
                    else
                    begin
                        if (rem_reg >= trial)
                            rem_reg <= rem_reg - trial;
                        root_reg <= root_step;
                        cnt_reg  <= cnt_reg + 6'd1;
                        if (cnt_reg == 6'd31)
                            len_reg <= root_step[32:0];
                    end
                end
                OP_DIV:
                begin
                    if (cmd.first)
                    begin
                        len_zero_reg <= (len_reg == 33'd0);
                        if (len_reg == 33'd0)
                            degen_reg <= 1'b1;
                        neg_reg  <= raw_reg[cmd.idx_k][31];
                        num_reg  <= 64'(raw_reg[cmd.idx_k][31]
                                     ? -65'sd0 - 65'(raw_reg[cmd.idx_k])
                                     : 65'(raw_reg[cmd.idx_k])) << FRAC_BITS;
                        drem_reg <= '0;
                        quo_reg  <= '0;
                        cnt_reg  <= '0;
                    end
                    else
                    begin
                        if (!dtrial[64])
                        begin
                            drem_reg <= dtrial;
                            quo_reg  <= {quo_reg[62:0], 1'b1};
                        end
                        else
                        begin
                            drem_reg <= {drem_reg[63:0], num_reg[63]};
                            quo_reg  <= {quo_reg[62:0], 1'b0};
                        end
                        num_reg <= num_reg << 1;
                        cnt_reg <= cnt_reg + 6'd1;
                    end
                end
                OP_DIST_MAC:
                    acc_reg <= (cmd.first ? 66'sd0 : acc_reg) + 66'(prod_fl);
                OP_DIST_CMP:
                begin
                    if (item.func == FUNC_SPHERE)
                    begin
                        if (dist_full <= -66'(sr_reg))
                            inside_reg <= 1'b0;
                    end
                    else if (dist_full[65])
                        inside_reg <= 1'b0;
                end
                OP_SR:
                    sr_reg <= 64'(sr_prod >> FRAC_BITS);
                default:
                    ;
            endcase
            // write divided component once the last quotient bit has landed
            if (cmd.op == OP_DIV && unit_fin)
            begin
                if (len_zero_reg)
                    plane_reg[{pidx, cmd.idx_k}] <= raw_reg[cmd.idx_k];
                else if (neg_reg)
                    plane_reg[{pidx, cmd.idx_k}] <=
                        sat32(-66'sd0 - 66'({1'b0, quo_reg[62:0], !dtrial[64]}));
                else
                    plane_reg[{pidx, cmd.idx_k}] <=
                        sat32(66'({1'b0, quo_reg[62:0], !dtrial[64]}));
            end
        end
    end

    assign stat.unit_done = done_reg;
    assign in_frustum     = inside_reg;
    assign degen          = degen_reg;

endmodule

@@ hw/rtl/fpec_ctrl.sv @@
module fpec_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [2:0]        func,
    input  fpec_pkg::dp_stat_t stat,
    output fpec_pkg::dp_cmd_t cmd,
    output logic              busy,
    output logic              done
);
    import fpec_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_CLIP   = 11'b00000000010,
        S_CLIPWR = 11'b00000000100,
        S_RAW    = 11'b00000001000,
        S_SQ     = 11'b00000010000,
        S_SQRT   = 11'b00000100000,
        S_DIV    = 11'b00001000000,
        S_SR     = 11'b00010000000,
        S_DMAC   = 11'b00100000000,
        S_DCMP   = 11'b01000000000,
        S_DONE   = 11'b10000000000
    } state_t;

    state_t     state_reg, state_next;
    logic [4:0] a_reg, a_next;
    logic [1:0] k_reg, k_next;
    logic       first_reg, first_next;

    always_comb
    begin
        state_next = state_reg;
        a_next     = a_reg;
        k_next     = k_reg;
        first_next = 1'b0;
        cmd        = '{op: OP_NONE, idx_a: a_reg, idx_k: k_reg, first: first_reg};
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op = OP_LOAD;
                    a_next = '0;
                    k_next = '0;
                    first_next = 1'b1;
                    if (func == FUNC_BUILD)
                        state_next = S_CLIP;
                    else if (func == FUNC_SPHERE || func == FUNC_POINT)
                        state_next = S_SR;
                    else
                        state_next = S_DONE;
                end
            end
            S_CLIP:
            begin
                cmd.op = OP_CLIP_MAC;
                k_next = k_reg + 2'd1;
                if (k_reg == 2'd3)
                    state_next = S_CLIPWR;
            end
            S_CLIPWR:
            begin
                cmd.op     = OP_CLIP_WR;
                first_next = 1'b1;
                a_next     = a_reg + 5'd1;
                if (a_reg == 5'd15)
                begin
                    a_next     = '0;
                    state_next = S_RAW;
                end
                else
                    state_next = S_CLIP;
            end
            S_RAW:
            begin
                cmd.op     = OP_RAW;
                first_next = 1'b1;
                k_next     = '0;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                cmd.op = OP_SQ_MAC;
                k_next = k_reg + 2'd1;
                if (k_reg == 2'd2)
                begin
                    k_next     = '0;
                    first_next = 1'b1;
                    state_next = S_SQRT;
                end
            end
            S_SQRT:
            begin
                cmd.op = OP_SQRT;
                if (stat.unit_done)
                begin
                    cmd.op     = OP_NONE;
                    first_next = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.op = OP_DIV;
                if (stat.unit_done)
                begin
                    cmd.op     = OP_NONE;
                    first_next = 1'b1;
                    k_next     = k_reg + 2'd1;
                    if (k_reg == 2'd3)
                    begin
                        k_next = '0;
                        a_next = a_reg + 5'd1;
                        state_next = (a_reg == 5'd5) ? S_DONE : S_RAW;
                    end
                end
            end
            S_SR:
            begin
                cmd.op     = OP_SR;
                a_next     = '0;
                k_next     = '0;
                first_next = 1'b1;
                state_next = S_DMAC;
            end
            S_DMAC:
            begin
                cmd.op = OP_DIST_MAC;
                k_next = k_reg + 2'd1;
                if (k_reg == 2'd2)
                begin
                    k_next     = '0;
                    state_next = S_DCMP;
                end
            end
            S_DCMP:
            begin
                cmd.op     = OP_DIST_CMP;
                first_next = 1'b1;
                a_next     = a_reg + 5'd1;
                state_next = (a_reg == 5'd5) ? S_DONE : S_DMAC;
            end
            S_DONE:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            a_reg     <= '0;
            k_reg     <= '0;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            a_reg     <= a_next;
            k_reg     <= k_next;
            first_reg <= first_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

endmodule

@@ hw/rtl/frustum_plane_extract_and_cull_core.sv @@
// Load and unused codes go straight to done; a point or sphere test runs the plane
// distance steps; a plane of zero length ends its divides early and shortens a build.
// Throughput: one item at a time; the next start is taken the cycle after done.
// The shared multiply-accumulate unit and the bit-serial sqrt/divide set the rate.
// Reset (asynchronous, rst_n low) clears both matrices, the planes, and sets
// radius_scale to 1.5. Results are strobed for one cycle; the receiver cannot stall.
module frustum_plane_extract_and_cull_core #(
    parameter int FRAC_BITS = fpec_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  fpec_pkg::in_item_t  item,
    output logic                result_valid,
    output fpec_pkg::out_item_t result,
    input  logic                cfg_we,
    input  logic [31:0]         cfg_wdata
);
    import fpec_pkg::*;

    // 1.5 in the configured fixed-point format
    localparam logic [31:0] RADIUS_SCALE_INIT = 32'd3 << (FRAC_BITS - 1);

    logic [31:0] radius_scale_reg;
    in_item_t    item_reg;
    dp_cmd_t     cmd;
    dp_stat_t    stat;
    logic        in_frustum;
    logic        degen;
    logic        done;

    // hold the radius factor; to be written only while idle, which the block does not enforce
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radius_scale_reg <= RADIUS_SCALE_INIT;
        else if (cfg_we)
            radius_scale_reg <= cfg_wdata;
    end

    // capture the item on transfer so the datapath sees it for the whole run
    always_ff @(posedge clk)
    begin
        if (start && !busy)
            item_reg <= item;
    end

    fpec_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .func  (item.func),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // load ops use the live item; later ops use the captured copy
    in_item_t dp_item;
    assign dp_item = (cmd.op == OP_LOAD) ? item : item_reg;

    fpec_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (dp_item),
        .radius_scale (radius_scale_reg),
        .cmd          (cmd),
        .stat         (stat),
        .in_frustum   (in_frustum),
        .degen        (degen)
    );

    assign result_valid      = done;
    assign result.inside_res = in_frustum;
    assign result.degenerate = degen;

endmodule

@@ tb/tb_frustum_plane_extract_and_cull_core.sv @@
module tb_frustum_plane_extract_and_cull_core;
    import fpec_pkg::*;

    localparam int FB = FRAC_BITS_DEF;
    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    in_item_t    item;
    logic        result_valid;
    out_item_t   result;
    logic        cfg_we;
    logic [31:0] cfg_wdata;

    frustum_plane_extract_and_cull_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Shadow copy of the block state, updated as each transfer is accepted.
    logic signed [31:0] proj_m [16];
    logic signed [31:0] view_m [16];
    logic signed [31:0] planes [24];
    logic [31:0]        scale_q;

    out_item_t expected_results[$];
    int  error_count = 0;
    int  idle_cycles = 0;
    int  send_gap_pct = 0;
    bit  timed_out = 0;

    function automatic logic signed [63:0] floor_shift(input logic signed [63:0] v);
        // arithmetic right shift is floor for two's complement
        return v >>> FB;
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic [63:0] root64(input logic [63:0] n);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] b;
        rem = n;
        root = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (rem >= root + b)
            begin
                rem = rem - (root + b);
                root = (root >> 1) + b;
            end
            else
                root = root >> 1;
            b = b >> 2;
        end
        return root;
    endfunction

    // Form the clip matrix, extract and normalize six planes; return degenerate.
    function automatic logic build_frustum();
        logic signed [31:0] clip [16];
        logic signed [63:0] acc;
        logic signed [31:0] raw [4];
        logic signed [63:0] w;
        logic signed [63:0] o;
        logic signed [63:0] num;
        logic [63:0] sumsq;
        logic [63:0] len;
        logic degen;
        int col;
        bit add;
        degen = 1'b0;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
            begin
                acc = 0;
                for (int k = 0; k < 4; k++)
                    acc += floor_shift(64'(view_m[r*4+k]) * 64'(proj_m[k*4+c]));
                clip[r*4+c] = clamp32(acc);
            end
        for (int p = 0; p < 6; p++)
        begin
            col = p >> 1;
            add = (p == 1 || p == 2 || p == 5);
            for (int k = 0; k < 4; k++)
            begin
                w = 64'(clip[k*4+3]);
                o = 64'(clip[k*4+col]);
                raw[k] = clamp32(add ? w + o : w - o);
            end
            sumsq = 0;
            for (int k = 0; k < 3; k++)
                sumsq += 64'(64'(raw[k]) * 64'(raw[k]));
            len = root64(sumsq);
            for (int k = 0; k < 4; k++)
            begin
                if (len == 0)
                    planes[p*4+k] = raw[k];
                else
                begin
                    num = 64'(raw[k]) <<< FB;
                    planes[p*4+k] = clamp32(num / $signed(len));
                end
            end
            if (len == 0)
                degen = 1'b1;
        end
        return degen;
    endfunction

    function automatic logic signed [63:0] plane_dist(input int p, input in_item_t it);
        logic signed [63:0] d;
        d = 64'(planes[p*4+3]);
        d += floor_shift(64'(planes[p*4+0]) * 64'(it.pos_x));
        d += floor_shift(64'(planes[p*4+1]) * 64'(it.pos_y));
        d += floor_shift(64'(planes[p*4+2]) * 64'(it.pos_z));
        return d;
    endfunction

    function automatic out_item_t predict_cull(input in_item_t it);
        out_item_t o;
        logic signed [63:0] sr;
        o = '0;
        case (it.func)
            FUNC_LOAD_PROJ: proj_m[it.elem_index] = it.elem_value;
            FUNC_LOAD_VIEW: view_m[it.elem_index] = it.elem_value;
            FUNC_BUILD:     o.degenerate = build_frustum();
            FUNC_SPHERE:
            begin
                sr = $signed((64'(it.sphere_radius) * 64'(scale_q)) >> FB);
                o.inside_res = 1'b1;
                for (int p = 0; p < 6; p++)
                    if (plane_dist(p, it) <= -sr)
                        o.inside_res = 1'b0;
            end
            FUNC_POINT:
            begin
                o.inside_res = 1'b1;
                for (int p = 0; p < 6; p++)
                    if (plane_dist(p, it) < 0)
                        o.inside_res = 1'b0;
            end
            default: ;
        endcase
        return o;
    endfunction

    // Check each strobed result against the oldest expectation.
    always @(posedge clk)
    begin
        out_item_t exp_r;
        if (rst_n && result_valid)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result inside_res=%0b degenerate=%0b",
                       result.inside_res, result.degenerate);
                error_count++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (result.inside_res !== exp_r.inside_res)
                begin
                    $error("inside_res expected %0b actual %0b",
                           exp_r.inside_res, result.inside_res);
                    error_count++;
                end
                if (result.degenerate !== exp_r.degenerate)
                begin
                    $error("degenerate expected %0b actual %0b",
                           exp_r.degenerate, result.degenerate);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: count cycles without any transfer in either direction.
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out = 1;
            $display("TEST FAILED");
            $finish;
        end
    end

    // Send one item: hold start until the edge where busy is low.
    // start stays high after the transfer; a gap or drain() drops it.
    task automatic send_item(input in_item_t it);
        while ($urandom_range(99) < send_gap_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_results.push_back(predict_cull(it));
    endtask

    task automatic drain();
        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Write the scale register while idle and mirror it.
    task automatic write_scale(input logic [31:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        scale_q = v;
        cfg_we  <= 1'b0;
    endtask

    function automatic in_item_t mk(input logic [2:0] f);
        in_item_t it;
        it = '0;
        it.func = f;
        return it;
    endfunction

    function automatic logic signed [31:0] rand_small();
        // values within a few units keep planes meaningful
        return $signed(32'($urandom_range(0, 6 << FB))) - (3 <<< FB);
    endfunction

    function automatic in_item_t rand_test(input bit sphere, input bit wide);
        in_item_t it;
        it = mk(sphere ? FUNC_SPHERE : FUNC_POINT);
        it.pos_x = wide ? $urandom : rand_small();
        it.pos_y = wide ? $urandom : rand_small();
        it.pos_z = wide ? $urandom : rand_small();
        it.sphere_radius = wide ? 31'($urandom) : 31'($urandom_range(0, 2 << FB));
        it.elem_index = 4'($urandom);
        it.elem_value = $urandom;
        return it;
    endfunction

    task automatic load_matrix(input logic [2:0] f, input bit wide);
        in_item_t it;
        for (int i = 0; i < 16; i++)
        begin
            it = mk(f);
            it.elem_index = 4'(i);
            if (wide)
                it.elem_value = $urandom;
            else if ($urandom_range(3) == 0)
                it.elem_value = 0;
            else
                it.elem_value = rand_small();
            send_item(it);
        end
    endtask

    // Directed: tests before any build, field extremes, unused codes, degenerate build.
    task automatic test_directed();
        in_item_t it;
        it = mk(FUNC_POINT);
        it.pos_x = 32'sh80000000;
        it.pos_y = 32'sh7fffffff;
        send_item(it);
        it = mk(FUNC_SPHERE);
        it.sphere_radius = '1;
        it.pos_z = -1;
        send_item(it);
        for (int f = 5; f < 8; f++)
        begin
            it = mk(3'(f));
            it.elem_value = '1;
            it.elem_index = '1;
            send_item(it);
        end
        // build on all-zero matrices: every plane degenerate
        send_item(mk(FUNC_BUILD));
        it = mk(FUNC_LOAD_PROJ);
        it.elem_index = 4'd15;
        it.elem_value = 32'sh7fffffff;
        send_item(it);
        it = mk(FUNC_LOAD_VIEW);
        it.elem_index = 4'd0;
        it.elem_value = 32'sh80000000;
        send_item(it);
        it = mk(FUNC_LOAD_VIEW);
        it.elem_index = 4'd15;
        it.elem_value = 32'sh7fffffff;
        send_item(it);
        send_item(mk(FUNC_BUILD));
        it = mk(FUNC_POINT);
        it.pos_x = 32'sh7fffffff;
        it.pos_y = 32'sh80000000;
        it.pos_z = 32'sh7fffffff;
        send_item(it);
        it = mk(FUNC_SPHERE);
        it.sphere_radius = '1;
        it.pos_x = 32'sh80000000;
        send_item(it);
    endtask

    // Random frustum: full load, build, then random tests and now and then an unused code.
    task automatic test_frames(input int frames, input bit wide_mats);
        for (int fr = 0; fr < frames; fr++)
        begin
            load_matrix(FUNC_LOAD_PROJ, wide_mats && $urandom_range(1));
            load_matrix(FUNC_LOAD_VIEW, wide_mats && $urandom_range(1));
            send_item(mk(FUNC_BUILD));
            repeat ($urandom_range(8, 20))
                send_item(rand_test(1'($urandom_range(1)), $urandom_range(5) == 0));
            if ($urandom_range(9) == 0)
                send_item(mk(3'($urandom_range(5, 7))));
        end
    endtask

    task automatic test_scale_extremes();
        write_scale(32'd0);
        test_frames(2, 0);
        write_scale(32'hffffffff);
        test_frames(2, 0);
        write_scale($urandom);
        test_frames(2, 1);
        write_scale(RADIUS_SCALE_RST);
    endtask

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        item      = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        for (int i = 0; i < 16; i++)
        begin
            proj_m[i] = 0;
            view_m[i] = 0;
        end
        for (int i = 0; i < 24; i++)
            planes[i] = 0;
        scale_q = RADIUS_SCALE_RST;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        // hold off until every expected result has come
        drain();
        send_gap_pct = 19;
        test_frames(5, 0);
        test_scale_extremes();
        send_gap_pct = 47;
        test_frames(4, 1);
        send_gap_pct = 0;
        test_frames(4, 0);
        drain();
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
